### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the modem receive notice parser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent at one edge implies consequent at the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/mrnp_pkg.sv
// Package for the modem receive notice parser: character codes, item types
// and the decimal reader step. No dependencies.
package mrnp_pkg;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int PREFIX_LEN   = 8;
  localparam int ID_START     = 9;
  localparam int LINE_MAX_DEF = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam logic [15:0] NUM_CAP = 16'hFFFF;

  // Decimal reader phases
  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_SAT    = 2'd3;

  // One classified notice character handed from front to back
  typedef struct packed {
    logic [7:0] char_v;
    logic       is_cr;
    logic       is_comma;
    logic       is_digit;
    logic       is_blank;
    logic [3:0] digit;
  } char_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] value;
  } num_t;

  // Expected notice prefix "+NSONMI:"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0: c = 8'h2B;
      3'd1: c = 8'h4E;
      3'd2: c = 8'h53;
      3'd3: c = 8'h4F;
      3'd4: c = 8'h4E;
      3'd5: c = 8'h4D;
      3'd6: c = 8'h49;
      3'd7: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // One character into a saturating decimal reader
  function automatic num_t num_step(input num_t cur, input char_t ch);
    num_t        r;
    logic [19:0] v;
    r = cur;
    v = ({4'd0, cur.value} << 3) + ({4'd0, cur.value} << 1) + {16'd0, ch.digit};
    unique case (cur.phase)
      PH_BLANK: begin
        if (ch.is_blank) begin
          r = cur;
        end else if (ch.is_digit) begin
          r.value = {12'd0, ch.digit};
          r.phase = PH_DIGITS;
        end else begin
          r.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (ch.is_digit) begin
          if (v > {4'd0, NUM_CAP}) begin
            r.value = NUM_CAP;
            r.phase = PH_SAT;
          end else begin
            r.value = v[15:0];
          end
        end else begin
          r.phase = PH_DONE;
        end
      end
      default: r = cur;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/mrnp_front.sv
// Front end of the notice parser: tracks line starts, finds notices and
// classifies their characters for the back end. Uses mrnp_pkg.
module mrnp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,        // input item accepted this cycle
  input  logic [7:0]         rx_byte,
  input  logic               rx_accepted,
  output logic               push,
  output mrnp_pkg::char_t    push_data
);

  logic lwlf_r, lwlf_nxt;
  logic in_notice_r, in_notice_nxt;
  logic notice_now;

  // Notice opens on '+' right after a line feed
  assign notice_now = in_notice_r || (lwlf_r && (rx_byte == mrnp_pkg::CH_PLUS));

  always_comb begin
    in_notice_nxt = in_notice_r;
    lwlf_nxt      = lwlf_r;
    push          = 1'b0;
    if (acc) begin
      in_notice_nxt = notice_now;
      if (notice_now && (rx_byte == mrnp_pkg::CH_CR)) begin
        in_notice_nxt = 1'b0;
        push          = 1'b1;
      end else if (notice_now && (rx_byte != mrnp_pkg::CH_LF)) begin
        push = 1'b1;
      end
      if (rx_accepted) begin
        lwlf_nxt = (rx_byte == mrnp_pkg::CH_LF);
      end
    end
  end

  // Character classification
  always_comb begin
    push_data.char_v   = rx_byte;
    push_data.is_cr    = (rx_byte == mrnp_pkg::CH_CR);
    push_data.is_comma = (rx_byte == mrnp_pkg::CH_COMMA);
    push_data.is_digit = (rx_byte >= mrnp_pkg::CH_ZERO) && (rx_byte <= mrnp_pkg::CH_NINE);
    push_data.is_blank = (rx_byte == 8'h20) || (rx_byte == 8'h09) ||
                         (rx_byte == 8'h0B) || (rx_byte == 8'h0C);
    push_data.digit    = rx_byte[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lwlf_r      <= 1'b1;
      in_notice_r <= 1'b0;
    end else begin
      lwlf_r      <= lwlf_nxt;
      in_notice_r <= in_notice_nxt;
    end
  end

endmodule

### rtl/core/mrnp_queue.sv
// Short register queue between the front and back ends of the notice parser.
// Uses mrnp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mrnp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrnp_pkg::char_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mrnp_pkg::char_t rd_data
);

  localparam int PtrW = $clog2(mrnp_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(mrnp_pkg::QUEUE_DEPTH + 1);

  mrnp_pkg::char_t mem_r [mrnp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(mrnp_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(mrnp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(mrnp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CntW'(mrnp_pkg::QUEUE_DEPTH))
  `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full || pop)
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, not_empty)

endmodule

### rtl/core/mrnp_back.sv
// Back end of the notice parser: prefix check, socket id and byte count
// readers, and the result register. Uses mrnp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mrnp_back #(
  parameter int LINE_MAX = mrnp_pkg::LINE_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            notify_enable,
  input  logic            q_valid,
  input  mrnp_pkg::char_t q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     socket_id,
  output logic [15:0]     byte_count,
  output logic            saturated
);

  localparam int PosW = $clog2(LINE_MAX + 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            prefix_ok_r, prefix_ok_nxt;
  logic            comma_r, comma_nxt;
  logic            over_r, over_nxt;
  mrnp_pkg::num_t  id_r, id_nxt;
  mrnp_pkg::num_t  cnt_r, cnt_nxt;
  logic            emit;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     sock_r, bcnt_r;
  logic            sat_r;

  assign pop = q_valid && (!out_valid_r || out_ready);

  // Line parsing, one character per pop
  always_comb begin
    pos_nxt       = pos_r;
    prefix_ok_nxt = prefix_ok_r;
    comma_nxt     = comma_r;
    over_nxt      = over_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    if (pop) begin
      if (q_data.is_cr) begin
        emit = notify_enable && prefix_ok_r && comma_r && !over_r &&
               (pos_r >= PosW'(mrnp_pkg::PREFIX_LEN));
        pos_nxt       = '0;
        prefix_ok_nxt = 1'b1;
        comma_nxt     = 1'b0;
        over_nxt      = 1'b0;
        id_nxt        = '0;
        cnt_nxt       = '0;
      end else if (!over_r) begin
        if (pos_r >= PosW'(LINE_MAX)) begin
          over_nxt = 1'b1;
        end else begin
          if ((pos_r < PosW'(mrnp_pkg::PREFIX_LEN)) &&
              (q_data.char_v != mrnp_pkg::prefix_char(pos_r[2:0]))) begin
            prefix_ok_nxt = 1'b0;
          end
          if (pos_r >= PosW'(mrnp_pkg::ID_START)) begin
            id_nxt = mrnp_pkg::num_step(id_r, q_data);
          end
          if (q_data.is_comma) begin
            comma_nxt = 1'b1;
            cnt_nxt   = '0;
          end else if (comma_r) begin
            cnt_nxt = mrnp_pkg::num_step(cnt_r, q_data);
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      prefix_ok_r <= 1'b1;
      comma_r     <= 1'b0;
      over_r      <= 1'b0;
      id_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      comma_r     <= comma_nxt;
      over_r      <= over_nxt;
      id_r        <= id_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      sock_r <= id_r.value;
      bcnt_r <= cnt_r.value;
      sat_r  <= (id_r.phase == mrnp_pkg::PH_SAT) || (cnt_r.phase == mrnp_pkg::PH_SAT);
    end
  end

  assign out_valid  = out_valid_r;
  assign socket_id  = sock_r;
  assign byte_count = bcnt_r;
  assign saturated  = sat_r;

  `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_r <= PosW'(LINE_MAX))
  `ASSERT_IMPL(a_over_at_max, clk, rst_n, over_r, pos_r == PosW'(LINE_MAX))
  `ASSERT_IMPL(a_emit_on_cr, clk, rst_n, emit, pop && q_data.is_cr)
  `ASSERT_NEXT(a_cr_clears, clk, rst_n, pop && q_data.is_cr, pos_r == '0 && !comma_r)

endmodule

### rtl/core/modem_receive_notice_parser.sv
// Top level of the modem receive notice parser: configuration register,
// front end, queue and back end. Uses mrnp_pkg, mrnp_front, mrnp_queue, mrnp_back.
//
// Channel  Direction  Content
// in_      slave      tdata: rx_byte[7:0]; tuser: rx_accepted
// out_     master     tdata: socket_id[15:0], byte_count[31:16]; tuser: saturated
// cfg_     write      cfg_wr_data: notify_enable
//
// One byte per cycle sustained while results are taken. With the queue empty,
// the closing CR is written to the queue at the edge that accepts it; popping
// it then loads the result register, which raises out_tvalid. Reset (rst_n
// low, synchronous) clears line tracking, the queue and the result valid
// flag; no clearing pass. A stalled result holds the back end, the two-entry
// queue absorbs the front end, then in_tready drops.
module modem_receive_notice_parser #(
  parameter int LINE_MAX = mrnp_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  input  logic        in_tuser,    // rx_accepted
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // socket_id, byte_count
  output logic        out_tuser,   // saturated
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // notify_enable
);

  logic            notify_en_r;
  logic            acc;
  logic            push, full, pop, q_valid;
  mrnp_pkg::char_t push_data, q_data;
  logic [15:0]     socket_id, byte_count;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      notify_en_r <= cfg_wr_data;
    end
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  mrnp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .rx_byte     (in_tdata),
    .rx_accepted (in_tuser),
    .push        (push),
    .push_data   (push_data)
  );

  mrnp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  mrnp_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .notify_enable (notify_en_r),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .socket_id     (socket_id),
    .byte_count    (byte_count),
    .saturated     (out_tuser)
  );

  assign out_tdata = {byte_count, socket_id};

endmodule
